@@ rtl/lifd_pkg.sv @@
// Shared types, constants and helpers for the LIF neuron with delay ring.
package lifd_pkg;

  localparam int DIV_W     = 36;
  localparam int DIV_STEPS = DIV_W / 4;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int REM_W     = 4;
  localparam int MOD_W     = 5;
  localparam int ACC_W     = 54;
  localparam int PROD_W    = 53;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_SPIKE = 1'b1;

  localparam logic [2:0] CFG_DECAY      = 3'd0;
  localparam logic [2:0] CFG_GAIN       = 3'd1;
  localparam logic [2:0] CFG_THRESHOLD  = 3'd2;
  localparam logic [2:0] CFG_RESET_POT  = 3'd3;
  localparam logic [2:0] CFG_REFRACTORY = 3'd4;
  localparam logic [2:0] CFG_DELAY      = 3'd5;
  localparam logic [2:0] CFG_SPIKE_W    = 3'd6;
  localparam logic [2:0] CFG_EXT_W      = 3'd7;

  localparam logic [15:0] DECAY_RST      = 16'd65209;
  localparam logic [19:0] GAIN_RST       = 20'd6537;
  localparam logic [31:0] THRESHOLD_RST  = 32'd1310720;
  localparam logic [31:0] RESET_POT_RST  = 32'd0;
  localparam logic [7:0]  REFRACTORY_RST = 8'd20;
  localparam logic [3:0]  DELAY_RST      = 4'd15;
  localparam logic [31:0] SPIKE_W_RST    = 32'd6554;
  localparam logic [31:0] EXT_W_RST      = 32'd6554;

  typedef struct packed {
    logic rd;
    logic wr;
    logic set_valid;
  } lifd_ring_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(64'sd2147483647);
    lo = ACC_W'(-64'sd2147483648);
    if (v > hi) begin
      return 32'sh7fff_ffff;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

@@ rtl/lifd_mod_unit.sv @@
// Iterative remainder unit, four dividend bits per cycle.
module lifd_mod_unit
  import lifd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [MOD_W-1:0] modulus,
  output logic             done,
  output logic [REM_W-1:0] rem
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     shreg;
  logic [MOD_W-1:0]     mod_q;
  logic [MOD_W-1:0]     r_work;

  always_comb begin
    r_work = {1'b0, rem};
    for (int i = 0; i < 4; i++) begin
      r_work = {r_work[REM_W-1:0], shreg[DIV_W-1-i]};
      if (r_work >= mod_q) begin
        r_work = r_work - mod_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == DIV_CNT_W'(DIV_STEPS - 1));
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        shreg <= dividend;
        mod_q <= modulus;
        rem   <= '0;
      end else if (busy) begin
        rem   <= r_work[REM_W-1:0];
        shreg <= shreg << 4;
        cnt   <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

@@ rtl/lifd_mul.sv @@
// Shared registered signed multiplier, 32-bit signed by 20-bit unsigned.
module lifd_mul
  import lifd_pkg::*;
(
  input  logic                     clk,
  input  logic signed [31:0]       a,
  input  logic        [19:0]       b,
  output logic signed [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * $signed({1'b0, b});
  end

endmodule

@@ rtl/lifd_ring.sv @@
// Delay ring memory with per-slot valid bits; an invalid slot reads as zero.
module lifd_ring
  import lifd_pkg::*;
#(
  parameter int RING_SLOTS = 16,
  parameter int SLOT_W     = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  lifd_ring_ctl_t      ctl,
  input  logic [SLOT_W-1:0]   addr,
  input  logic signed [31:0]  wdata,
  output logic signed [31:0]  rdata
);

  logic signed [31:0]    mem [RING_SLOTS];
  logic [RING_SLOTS-1:0] vld;
  logic signed [31:0]    q_mem;
  logic                  q_vld;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd) begin
      q_mem <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      q_vld <= 1'b0;
    end else begin
      if (ctl.wr) begin
        vld[addr] <= ctl.set_valid;
      end
      if (ctl.rd) begin
        q_vld <= vld[addr];
      end
    end
  end

  assign rdata = q_vld ? q_mem : 32'sd0;

endmodule

@@ rtl/lif_neuron_with_delay_ring.sv @@
// Top level: leaky integrate-and-fire neuron with refractory period and delay ring.
//
// Item channel (item_valid/item_stall): opcode 0 is a tick, opcode 1 a presynaptic
// spike. Result channel (result_valid/result_stall): one result per item carrying
// spiked, potential and spike_total. Config writes (cfg_write/cfg_index/cfg_data)
// go straight into the registers; the user must make them only while the block is
// idle, which the block itself does not enforce. One item is worked at a time;
// item_stall is high from acceptance until the result is placed in the output
// register. The ring slot is found by an iterative remainder unit (four dividend
// bits per step), and the three products share one registered multiplier. A tick
// in the refractory period goes straight to output; other items run the remainder
// unit and a ring read, then a tick the products and sum, a spike a ring update.
// The result register frees the input side: a new item is accepted while a result
// still waits; if the receiver stalls, the next result waits in its final state.
// Reset clears the membrane, refractory count, spike counter and all ring slots
// (per-slot valid bits) and loads the default register values; no clearing pass.
module lif_neuron_with_delay_ring
  import lifd_pkg::*;
#(
  parameter int RING_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               opcode,
  input  logic [31:0]        step_time,
  input  logic signed [31:0] drive_current,
  input  logic [7:0]         external_events,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               spiked,
  output logic signed [31:0] potential,
  output logic [31:0]        spike_total,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int SLOT_W = $clog2(RING_SLOTS);

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_RD, S_SPK, S_MUL1, S_MUL2, S_MUL3, S_SUM, S_FIN, S_OUT
  } state_t;

  state_t state;

  logic [15:0]        decay_factor;
  logic [19:0]        input_gain;
  logic signed [31:0] fire_threshold;
  logic signed [31:0] reset_potential;
  logic [7:0]         refractory_steps;
  logic [3:0]         delay_steps;
  logic signed [31:0] spike_weight;
  logic signed [31:0] external_weight;

  logic signed [31:0] membrane;
  logic [7:0]         refractory_left;
  logic [31:0]        spike_counter;
  logic               fired;
  logic               op_q;
  logic signed [31:0] cur_q;
  logic [7:0]         events_q;
  logic [SLOT_W-1:0]  slot;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] sum;

  logic                    accept;
  logic [MOD_W-1:0]        delay_p1;
  logic [MOD_W-1:0]        modulus;
  logic [DIV_W-1:0]        dividend;
  logic                    mod_start;
  logic                    mod_done;
  logic [REM_W-1:0]        mod_rem;
  logic signed [31:0]      mul_a;
  logic [19:0]             mul_b;
  logic signed [PROD_W-1:0] prod;
  lifd_ring_ctl_t          ring_ctl;
  logic signed [31:0]      ring_wdata;
  logic signed [31:0]      ring_rdata;
  logic signed [ACC_W-1:0] rounded;
  logic signed [31:0]      mem_sat;
  logic                    out_free;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  assign delay_p1  = {1'b0, delay_steps} + MOD_W'(1);
  assign modulus   = (int'(delay_p1) > RING_SLOTS) ? MOD_W'(RING_SLOTS) : delay_p1;
  assign dividend  = (opcode == OP_SPIKE) ?
                     {3'b000, {1'b0, step_time} + {29'd0, delay_steps}} :
                     {4'b0000, step_time};
  assign mod_start = accept && ((opcode == OP_SPIKE) || (refractory_left == 8'd0));

  lifd_mod_unit u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (dividend),
    .modulus  (modulus),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_comb begin
    mul_a = membrane;
    mul_b = {4'd0, decay_factor};
    case (state)
      S_MUL2: begin
        mul_a = cur_q;
        mul_b = input_gain;
      end
      S_MUL3: begin
        mul_a = external_weight;
        mul_b = {12'd0, events_q};
      end
      default: begin
        mul_a = membrane;
        mul_b = {4'd0, decay_factor};
      end
    endcase
  end

  lifd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  always_comb begin
    ring_ctl   = '0;
    ring_wdata = '0;
    case (state)
      S_RD: ring_ctl.rd = 1'b1;
      S_SPK: begin
        ring_ctl.wr        = 1'b1;
        ring_ctl.set_valid = 1'b1;
        ring_wdata = sat32(ACC_W'(ring_rdata) + ACC_W'(spike_weight));
      end
      S_FIN: ring_ctl.wr = 1'b1;
      default: ring_ctl = '0;
    endcase
  end

  lifd_ring #(
    .RING_SLOTS (RING_SLOTS),
    .SLOT_W     (SLOT_W)
  ) u_ring (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ring_ctl),
    .addr  (slot),
    .wdata (ring_wdata),
    .rdata (ring_rdata)
  );

  assign rounded = (acc + ACC_W'(32768)) >>> 16;
  assign mem_sat = sat32(sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_factor     <= DECAY_RST;
      input_gain       <= GAIN_RST;
      fire_threshold   <= THRESHOLD_RST;
      reset_potential  <= RESET_POT_RST;
      refractory_steps <= REFRACTORY_RST;
      delay_steps      <= DELAY_RST;
      spike_weight     <= SPIKE_W_RST;
      external_weight  <= EXT_W_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DECAY:      decay_factor     <= cfg_data[15:0];
        CFG_GAIN:       input_gain       <= cfg_data[19:0];
        CFG_THRESHOLD:  fire_threshold   <= cfg_data;
        CFG_RESET_POT:  reset_potential  <= cfg_data;
        CFG_REFRACTORY: refractory_steps <= cfg_data[7:0];
        CFG_DELAY:      delay_steps      <= cfg_data[3:0];
        CFG_SPIKE_W:    spike_weight     <= cfg_data;
        CFG_EXT_W:      external_weight  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      membrane        <= '0;
      refractory_left <= '0;
      spike_counter   <= '0;
      fired           <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      if ((state == S_OUT) && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q     <= opcode;
            cur_q    <= drive_current;
            events_q <= external_events;
            fired    <= 1'b0;
            if (mod_start) begin
              state <= S_MOD;
            end else begin
              membrane        <= reset_potential;
              refractory_left <= refractory_left - 8'd1;
              state           <= S_OUT;
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            slot  <= SLOT_W'(mod_rem);
            state <= S_RD;
          end
        end
        S_RD:   state <= (op_q == OP_SPIKE) ? S_SPK : S_MUL1;
        S_SPK:  state <= S_OUT;
        S_MUL1: state <= S_MUL2;
        S_MUL2: begin
          acc   <= ACC_W'(prod);
          state <= S_MUL3;
        end
        S_MUL3: begin
          acc   <= acc + ACC_W'(prod);
          state <= S_SUM;
        end
        S_SUM: begin
          sum   <= rounded + ACC_W'(ring_rdata) + ACC_W'(prod);
          state <= S_FIN;
        end
        S_FIN: begin
          if (mem_sat > fire_threshold) begin
            spike_counter   <= spike_counter + 32'd1;
            membrane        <= reset_potential;
            refractory_left <= refractory_steps;
            fired           <= 1'b1;
          end else begin
            membrane <= mem_sat;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            spiked       <= fired;
            potential    <= membrane;
            spike_total  <= spike_counter;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the LIF neuron with delay ring: predictor, directed and random items.
module tb_top;
  import lifd_pkg::*;

  localparam int RING_SLOTS     = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;

  typedef struct packed {
    logic               spiked;
    logic signed [31:0] potential;
    logic [31:0]        spike_total;
  } neuron_out_t;

  logic               clk;
  logic               rst;
  logic               item_valid;
  logic               item_stall;
  logic               opcode;
  logic [31:0]        step_time;
  logic signed [31:0] drive_current;
  logic [7:0]         external_events;
  logic               result_valid;
  logic               result_stall;
  logic               spiked;
  logic signed [31:0] potential;
  logic [31:0]        spike_total;
  logic               cfg_write;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;

  lif_neuron_with_delay_ring #(.RING_SLOTS(RING_SLOTS)) DUT (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .opcode(opcode), .step_time(step_time),
    .drive_current(drive_current), .external_events(external_events),
    .result_valid(result_valid), .result_stall(result_stall),
    .spiked(spiked), .potential(potential), .spike_total(spike_total),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // register shadows
  logic [15:0]        decay_q16;
  logic [19:0]        gain_q16;
  logic signed [31:0] threshold_mv;
  logic signed [31:0] reset_mv;
  logic [7:0]         refr_steps;
  logic [3:0]         delay_ticks;
  logic signed [31:0] spike_w;
  logic signed [31:0] ext_w;

  // neuron state
  logic signed [31:0] membrane_mv;
  logic [7:0]         refr_left;
  logic signed [31:0] delay_slots [RING_SLOTS];
  logic [31:0]        fire_count;

  neuron_out_t expected_q[$];
  neuron_out_t due;

  int sender_idle_pct;
  int receiver_idle_pct;
  int hold_len;
  int failures;
  int items_sent;
  int results_checked;
  int spikes_seen;
  int settings_applied;
  int idle_cycles;
  logic [31:0] sim_step;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void reset_model();
    decay_q16    = DECAY_RST;
    gain_q16     = GAIN_RST;
    threshold_mv = THRESHOLD_RST;
    reset_mv     = RESET_POT_RST;
    refr_steps   = REFRACTORY_RST;
    delay_ticks  = DELAY_RST;
    spike_w      = SPIKE_W_RST;
    ext_w        = EXT_W_RST;
    membrane_mv  = '0;
    refr_left    = '0;
    fire_count   = '0;
    for (int i = 0; i < RING_SLOTS; i++) delay_slots[i] = '0;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic neuron_out_t neuron_step(input logic op, input logic [31:0] t,
                                              input logic signed [31:0] cur,
                                              input logic [7:0] ev);
    neuron_out_t r;
    longint modulus, slot, tl, d, g, m, c, acc, v, ring_v, w, n;
    modulus = delay_ticks + 1;
    if (modulus > RING_SLOTS) modulus = RING_SLOTS;
    tl = t;
    r.spiked = 1'b0;
    if (op == OP_SPIKE) begin
      slot = (tl + delay_ticks) % modulus;
      ring_v = delay_slots[slot];
      w = spike_w;
      delay_slots[slot] = 32'(clamp32(ring_v + w));
    end else if (refr_left > 0) begin
      membrane_mv = reset_mv;
      refr_left = refr_left - 8'd1;
    end else begin
      slot = tl % modulus;
      d = decay_q16;
      g = gain_q16;
      m = membrane_mv;
      c = cur;
      acc = d * m + g * c + 64'sd32768;
      v = acc >>> 16;
      ring_v = delay_slots[slot];
      w = ext_w;
      n = ev;
      v = v + ring_v + w * n;
      membrane_mv = 32'(clamp32(v));
      delay_slots[slot] = '0;
      if (membrane_mv > threshold_mv) begin
        fire_count = fire_count + 32'd1;
        membrane_mv = reset_mv;
        refr_left = refr_steps;
        r.spiked = 1'b1;
      end
    end
    r.potential = membrane_mv;
    r.spike_total = fire_count;
    return r;
  endfunction

  task automatic note_failure(input string what);
    failures++;
    if (failures <= 10) $display("  mismatch: %s", what);
  endtask

  task automatic send_item(input logic op, input logic [31:0] t,
                           input logic signed [31:0] cur, input logic [7:0] ev);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid      <= 1'b1;
    opcode          <= op;
    step_time       <= t;
    drive_current   <= cur;
    external_events <= ev;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    expected_q = {expected_q, neuron_step(op, t, cur, ev)};
    items_sent++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_DECAY:      decay_q16    = val[15:0];
      CFG_GAIN:       gain_q16     = val[19:0];
      CFG_THRESHOLD:  threshold_mv = val;
      CFG_RESET_POT:  reset_mv     = val;
      CFG_REFRACTORY: refr_steps   = val[7:0];
      CFG_DELAY:      delay_ticks  = val[3:0];
      CFG_SPIKE_W:    spike_w      = val;
      CFG_EXT_W:      ext_w        = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic apply_setting(input int kind);
    logic [31:0] v [8];
    wait_idle();
    case (kind)
      0: begin
        v = '{DECAY_RST, GAIN_RST, THRESHOLD_RST, RESET_POT_RST,
              $urandom_range(0, 6), $urandom_range(0, 15), SPIKE_W_RST, EXT_W_RST};
      end
      1: begin
        v = '{32'h0000_FFFF, 32'h000F_FFFF, 32'h0010_0000, 32'h8000_0000,
              32'd255, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000};
      end
      2: begin
        v = '{32'd0, 32'h0001_0000, 32'h8000_0000, 32'd0,
              32'd0, 32'd15, $urandom, 32'd0};
      end
      default: begin
        v[0] = $urandom_range(0, 16'hFFFF);
        v[1] = $urandom_range(0, 20'h3FFFF);
        v[2] = $urandom_range(0, 32'h0040_0000) - 32'h0010_0000;
        v[3] = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        v[4] = $urandom_range(0, 8);
        v[5] = $urandom_range(0, 15);
        v[6] = $urandom_range(0, 32'h0004_0000) - 32'h0001_0000;
        v[7] = $urandom_range(0, 32'h0004_0000) - 32'h0001_0000;
      end
    endcase
    write_reg(CFG_DECAY,      v[0]);
    write_reg(CFG_GAIN,       v[1]);
    write_reg(CFG_THRESHOLD,  v[2]);
    write_reg(CFG_RESET_POT,  v[3]);
    write_reg(CFG_REFRACTORY, v[4]);
    write_reg(CFG_DELAY,      v[5]);
    write_reg(CFG_SPIKE_W,    v[6]);
    write_reg(CFG_EXT_W,      v[7]);
    settings_applied++;
  endtask

  // mostly ordered ticks with spikes at the current step; some full-range noise
  task automatic random_items(input int count);
    logic signed [31:0] cur;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 85) begin
        cur = $urandom_range(0, 32'h0100_0000) - 32'h0040_0000;
        if ($urandom_range(3) == 0) begin
          send_item(OP_SPIKE, sim_step, cur, 8'($urandom_range(255)));
        end else begin
          send_item(OP_TICK, sim_step, cur, 8'($urandom_range(0, 20)));
          sim_step = sim_step + 1;
        end
      end else begin
        send_item(1'($urandom_range(1)), $urandom, $urandom, 8'($urandom_range(255)));
      end
    end
  endtask

  // equal to threshold must not fire; refractory hold; spike during refractory
  task automatic test_threshold_edge();
    write_reg(CFG_DECAY, 32'd0);
    write_reg(CFG_GAIN, 32'd0);
    write_reg(CFG_THRESHOLD, 32'h0001_0000);
    write_reg(CFG_EXT_W, 32'h0000_8000);
    write_reg(CFG_REFRACTORY, 32'd1);
    write_reg(CFG_RESET_POT, 32'hFFFF_8000);
    write_reg(CFG_DELAY, 32'd2);
    send_item(OP_TICK, 32'd0, 32'sd0, 8'd2);
    send_item(OP_TICK, 32'd1, 32'sd0, 8'd3);
    send_item(OP_SPIKE, 32'd1, 32'sd0, 8'd0);
    send_item(OP_TICK, 32'd2, 32'sd0, 8'd0);
    send_item(OP_TICK, 32'd3, 32'sd0, 8'd0);
    send_item(OP_TICK, 32'd4, 32'sd0, 8'd0);
  endtask

  task automatic test_ring_saturation();
    wait_idle();
    write_reg(CFG_DELAY, 32'd0);
    write_reg(CFG_REFRACTORY, 32'd0);
    write_reg(CFG_EXT_W, 32'd0);
    write_reg(CFG_THRESHOLD, 32'h7FFF_FFFF);
    write_reg(CFG_SPIKE_W, 32'h7FFF_FFFF);
    repeat (3) send_item(OP_SPIKE, 32'd5, 32'sd0, 8'd0);
    send_item(OP_TICK, 32'd5, 32'sd0, 8'd0);
    wait_idle();
    write_reg(CFG_SPIKE_W, 32'h8000_0000);
    repeat (3) send_item(OP_SPIKE, 32'd6, 32'sd0, 8'd0);
    send_item(OP_TICK, 32'd6, 32'sd0, 8'd0);
  endtask

  task automatic test_field_extremes();
    wait_idle();
    write_reg(CFG_DECAY, 32'h0000_FFFF);
    write_reg(CFG_GAIN, 32'h000F_FFFF);
    write_reg(CFG_THRESHOLD, 32'h8000_0000);
    write_reg(CFG_RESET_POT, 32'h8000_0000);
    write_reg(CFG_EXT_W, 32'h8000_0000);
    write_reg(CFG_DELAY, 32'd15);
    send_item(OP_TICK, 32'hFFFF_FFFF, 32'sh8000_0000, 8'hFF);
    send_item(OP_TICK, 32'd0, 32'sh7FFF_FFFF, 8'h00);
    send_item(OP_SPIKE, 32'hFFFF_FFFF, 32'shFFFF_FFFF, 8'hFF);
    send_item(OP_SPIKE, 32'd0, 32'sd0, 8'h00);
    send_item(OP_TICK, 32'd14, 32'sd0, 8'h00);
  endtask

  // receiver holds off while items keep coming, so the block backs up its input
  task automatic test_backpressure();
    int saved;
    saved = sender_idle_pct;
    wait_idle();
    sender_idle_pct = 0;
    hold_len = HOLD_CYCLES;
    random_items(8);
    sender_idle_pct = saved;
  endtask

  task automatic test_random_phase(input int s_pct, input int r_pct,
                                   input int kind_a, input int kind_b);
    sender_idle_pct = s_pct;
    receiver_idle_pct = r_pct;
    apply_setting(kind_a);
    random_items(290);
    apply_setting(kind_b);
    random_items(290);
  endtask

  task automatic finish_run();
    wait_idle();
    repeat (20) @(negedge clk);
    $display("Ran %0d items (directed extremes, threshold, ring saturation, backpressure)",
             items_sent);
    $display("and %0d random settings; %0d results checked, %0d of them spikes",
             settings_applied, results_checked, spikes_seen);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  endtask

  // receiver stall
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        result_stall <= 1'b1;
        for (int n = 0; n < hold_len; n++) @(negedge clk);
        hold_len = 0;
      end
      result_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      results_checked++;
      if (expected_q.size() == 0) begin
        note_failure("result arrived with nothing expected");
      end else begin
        due = expected_q.pop_front();
        if (due.spiked) spikes_seen++;
        if (spiked !== due.spiked)
          note_failure($sformatf("spiked exp %0d got %0d", due.spiked, spiked));
        if (potential !== due.potential)
          note_failure($sformatf("potential exp %0d got %0d", due.potential, potential));
        if (spike_total !== due.spike_total)
          note_failure($sformatf("spike_total exp %0d got %0d",
                                 due.spike_total, spike_total));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", idle_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    opcode = OP_TICK;
    step_time = '0;
    drive_current = '0;
    external_events = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_DECAY;
    cfg_data = '0;
    sender_idle_pct = 34;
    receiver_idle_pct = 47;
    hold_len = 0;
    failures = 0;
    items_sent = 0;
    results_checked = 0;
    spikes_seen = 0;
    settings_applied = 0;
    idle_cycles = 0;
    sim_step = '0;
    reset_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_threshold_edge();
    test_ring_saturation();
    test_field_extremes();
    test_random_phase(34, 47, 0, 1);
    test_backpressure();
    test_random_phase(47, 34, 2, 3);
    test_random_phase(0, 0, 4, 5);
    finish_run();
  end

endmodule

@@ sim.f @@
rtl/lifd_pkg.sv
rtl/lifd_mod_unit.sv
rtl/lifd_mul.sv
rtl/lifd_ring.sv
rtl/lif_neuron_with_delay_ring.sv
bench/tb_top.sv
